// ===== design/hta_pkg.sv =====
// shared widths, constants and types of the triangle and circle measurement unit
package hta_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int GUARD_BITS  = 8;

    localparam int AREA_W  = 24;
    localparam int PERIM_W = 20;
    localparam logic [AREA_W-1:0]  AREA_MAX  = '1;
    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;

    // side lane widths
    localparam int SQR_W      = 2 * COORD_WIDTH;
    localparam int D2_W       = 2 * COORD_WIDTH + 1;
    localparam int RAD_W      = D2_W + 2 * GUARD_BITS;
    localparam int SIDE_RAD_W = RAD_W + (RAD_W % 2);
    localparam int SIDE_W     = SIDE_RAD_W / 2;
    localparam int LANE_LAT   = 3 + SIDE_W;

    // heron product widths
    localparam int SUM_W       = SIDE_W + 2;
    localparam int FAC_W       = SIDE_W + 1;
    localparam int X_W         = SUM_W + FAC_W;
    localparam int Y_W         = 2 * FAC_W;
    localparam int X_LO_W      = (X_W + 1) / 2;
    localparam int X_HI_W      = X_W - X_LO_W;
    localparam int Y_LO_W      = Y_W / 2;
    localparam int Y_HI_W      = Y_W - Y_LO_W;
    localparam int PROD_W      = X_W + Y_W;
    localparam int HERON_SH    = 2 * FRAC_BITS + 4 * GUARD_BITS + 4;
    localparam int P_W         = PROD_W - HERON_SH;
    localparam int AREA_RAD_W  = P_W + (P_W % 2);
    localparam int AREA_ROOT_W = AREA_RAD_W / 2;

    // circle widths, pi in q.32
    localparam int R_W      = COORD_WIDTH - 1;
    localparam int R2_W     = 2 * R_W;
    localparam int PI_W     = 34;
    localparam int PI_LO_W  = PI_W / 2;
    localparam int PI_HI_W  = PI_W - PI_LO_W;
    localparam logic [PI_W-1:0] PI_Q32 = 34'd13493037705;
    localparam int CA_W     = R2_W + PI_W;
    localparam int CA_SH    = 32 + FRAC_BITS;
    localparam int CP_W     = R_W + 1 + PI_W;
    localparam int CP_SH    = 32;

    // stream widths
    localparam int S_TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((AREA_W + PERIM_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - AREA_W - PERIM_W;

    typedef enum logic {
        OP_TRIANGLE = 1'b0,
        OP_CIRCLE   = 1'b1
    } opcode_t;

endpackage

// ===== design/hta_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module hta_isqrt #(
    parameter int IN_W = 50
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     rad_in,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root_out
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic [IN_W-1:0]   rad_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] valid_reg;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic [IN_W-1:0]   rad_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [REM_W-1:0]  rem_cur;
        logic              valid_cur;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (i == 0) begin : g_first
            assign rad_cur   = rad_in;
            assign root_cur  = '0;
            assign rem_cur   = '0;
            assign valid_cur = in_valid;
        end else begin : g_rest
            assign rad_cur   = rad_reg[i-1];
            assign root_cur  = root_reg[i-1];
            assign rem_cur   = rem_reg[i-1];
            assign valid_cur = valid_reg[i-1];
        end

        always_comb begin
            rem_sh = {rem_cur[REM_W-3:0], rad_cur[IN_W-1 -: 2]};
            trial  = {1'b0, root_cur, 2'b01};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_cur[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_cur[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i]  <= {rad_cur[IN_W-3:0], 2'b00};
                root_reg[i] <= root_next;
                rem_reg[i]  <= rem_next;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root_out  = root_reg[ROOT_W-1];

endmodule

// ===== design/hta_lane.sv =====
// one side lane: distance squared between two points and its guarded square root
module hta_lane
    import hta_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] x0,
    input  logic signed [COORD_WIDTH-1:0] y0,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    output logic                          out_valid,
    output logic [SIDE_W-1:0]             side_len
);

    logic [COORD_WIDTH:0]   ddx;
    logic [COORD_WIDTH:0]   ddy;
    logic [COORD_WIDTH:0]   ddx_abs;
    logic [COORD_WIDTH:0]   ddy_abs;
    logic [COORD_WIDTH-1:0] dx_reg;
    logic [COORD_WIDTH-1:0] dy_reg;
    logic [SQR_W-1:0]       sqx_reg;
    logic [SQR_W-1:0]       sqy_reg;
    logic [D2_W-1:0]        d2_reg;
    logic [2:0]             vld_reg;
    logic [SIDE_RAD_W-1:0]  rad;

    assign ddx     = {x1[COORD_WIDTH-1], x1} - {x0[COORD_WIDTH-1], x0};
    assign ddy     = {y1[COORD_WIDTH-1], y1} - {y0[COORD_WIDTH-1], y0};
    assign ddx_abs = ddx[COORD_WIDTH] ? -ddx : ddx;
    assign ddy_abs = ddy[COORD_WIDTH] ? -ddy : ddy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= ddx_abs[COORD_WIDTH-1:0];
            dy_reg  <= ddy_abs[COORD_WIDTH-1:0];
            sqx_reg <= SQR_W'(dx_reg) * SQR_W'(dx_reg);
            sqy_reg <= SQR_W'(dy_reg) * SQR_W'(dy_reg);
            d2_reg  <= D2_W'(sqx_reg) + D2_W'(sqy_reg);
        end
    end

    assign rad = SIDE_RAD_W'({d2_reg, {(2 * GUARD_BITS){1'b0}}});

    hta_isqrt #(
        .IN_W (SIDE_RAD_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[2]),
        .rad_in    (rad),
        .out_valid (out_valid),
        .root_out  (side_len)
    );

endmodule

// ===== design/hta_merge.sv =====
// merge stage: perimeter, heron area from the three sides, circle results, output select
module hta_merge
    import hta_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [SIDE_W-1:0]             side_a,
    input  logic [SIDE_W-1:0]             side_b,
    input  logic [SIDE_W-1:0]             side_c,
    input  opcode_t                       opcode,
    input  logic signed [COORD_WIDTH-1:0] radius,
    output logic                          out_valid,
    output logic [AREA_W-1:0]             area,
    output logic [PERIM_W-1:0]            perimeter,
    output logic                          error
);

    typedef struct packed {
        opcode_t              op;
        logic                 rneg;
        logic [PERIM_W-1:0]   t_perim;
        logic [AREA_W-1:0]    c_area;
        logic [PERIM_W-1:0]   c_perim;
    } tag_t;

    // stage 1
    logic [SIDE_W:0]    bc, ac, ab;
    logic [SUM_W-1:0]   s_next;
    logic [SUM_W-1:0]   s_reg;
    logic [FAC_W-1:0]   fa_reg, fb_reg, fc_reg;
    logic               ok1_reg;
    logic [PERIM_W-1:0] tp_next;
    logic [PERIM_W-1:0] tp1_reg;
    opcode_t            op1_reg;
    logic               rneg1_reg;
    logic [R2_W-1:0]    r2_reg;
    logic [R_W:0]       tr_reg;

    // stage 2
    logic [X_W-1:0]             x_reg;
    logic [Y_W-1:0]             y_reg;
    logic                       ok2_reg;
    logic [PERIM_W-1:0]         tp2_reg;
    opcode_t                    op2_reg;
    logic                       rneg2_reg;
    logic [R2_W+PI_LO_W-1:0]    ca_lo_reg;
    logic [R2_W+PI_HI_W-1:0]    ca_hi_reg;
    logic [R_W+PI_LO_W:0]       cp_lo_reg;
    logic [R_W+PI_HI_W:0]       cp_hi_reg;

    // stage 3
    logic [CA_W-1:0]            ca;
    logic [CA_W-1:0]            ca_sh;
    logic [CP_W-1:0]            cp;
    logic [CP_W-1:0]            cp_sh;
    tag_t                       tag_next;
    tag_t                       tag3_reg;
    logic                       ok3_reg;
    logic [X_LO_W+Y_LO_W-1:0]   pp_ll_reg;
    logic [X_LO_W+Y_HI_W-1:0]   pp_lh_reg;
    logic [X_HI_W+Y_LO_W-1:0]   pp_hl_reg;
    logic [X_HI_W+Y_HI_W-1:0]   pp_hh_reg;

    // stage 4, 5
    tag_t                  tag4_reg;
    tag_t                  tag5_reg;
    logic                  ok4_reg;
    logic [PROD_W-1:0]     cat_reg;
    logic [PROD_W-1:0]     mid_reg;
    logic [PROD_W-1:0]     prod;
    logic [AREA_RAD_W-1:0] p_reg;

    logic [4:0]             vld_reg;
    tag_t                   tag_dly_reg [AREA_ROOT_W];
    logic                   root_valid;
    logic [AREA_ROOT_W-1:0] root;
    tag_t                   tag_out;
    logic [AREA_W-1:0]      t_area;

    logic                   out_valid_reg;
    logic [AREA_W-1:0]      area_reg;
    logic [PERIM_W-1:0]     perimeter_reg;
    logic                   error_reg;

    assign bc     = {1'b0, side_b} + {1'b0, side_c};
    assign ac     = {1'b0, side_a} + {1'b0, side_c};
    assign ab     = {1'b0, side_a} + {1'b0, side_b};
    assign s_next = SUM_W'(side_a) + SUM_W'(side_b) + SUM_W'(side_c);
    assign tp_next = ((s_next >> GUARD_BITS) > SUM_W'(PERIM_MAX))
                   ? PERIM_MAX : PERIM_W'(s_next >> GUARD_BITS);

    assign ca    = CA_W'(ca_lo_reg) + (CA_W'(ca_hi_reg) << PI_LO_W);
    assign ca_sh = ca >> CA_SH;
    assign cp    = CP_W'(cp_lo_reg) + (CP_W'(cp_hi_reg) << PI_LO_W);
    assign cp_sh = cp >> CP_SH;

    always_comb begin
        tag_next.op      = op2_reg;
        tag_next.rneg    = rneg2_reg;
        tag_next.t_perim = tp2_reg;
        tag_next.c_area  = (ca_sh > CA_W'(AREA_MAX)) ? AREA_MAX : AREA_W'(ca_sh);
        tag_next.c_perim = (cp_sh > CP_W'(PERIM_MAX)) ? PERIM_MAX : PERIM_W'(cp_sh);
    end

    assign prod = cat_reg + mid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg     <= s_next;
            fa_reg    <= FAC_W'(bc - {1'b0, side_a});
            fb_reg    <= FAC_W'(ac - {1'b0, side_b});
            fc_reg    <= FAC_W'(ab - {1'b0, side_c});
            ok1_reg   <= (bc > {1'b0, side_a}) && (ac > {1'b0, side_b}) &&
                         (ab > {1'b0, side_c});
            tp1_reg   <= tp_next;
            op1_reg   <= opcode;
            rneg1_reg <= radius[COORD_WIDTH-1];
            r2_reg    <= R2_W'(radius[R_W-1:0]) * R2_W'(radius[R_W-1:0]);
            tr_reg    <= {radius[R_W-1:0], 1'b0};

            x_reg     <= X_W'(s_reg) * X_W'(fa_reg);
            y_reg     <= Y_W'(fb_reg) * Y_W'(fc_reg);
            ok2_reg   <= ok1_reg;
            tp2_reg   <= tp1_reg;
            op2_reg   <= op1_reg;
            rneg2_reg <= rneg1_reg;
            ca_lo_reg <= (R2_W + PI_LO_W)'(r2_reg) * (R2_W + PI_LO_W)'(PI_Q32[PI_LO_W-1:0]);
            ca_hi_reg <= (R2_W + PI_HI_W)'(r2_reg) * (R2_W + PI_HI_W)'(PI_Q32[PI_W-1:PI_LO_W]);
            cp_lo_reg <= (R_W + PI_LO_W + 1)'(tr_reg) * (R_W + PI_LO_W + 1)'(PI_Q32[PI_LO_W-1:0]);
            cp_hi_reg <= (R_W + PI_HI_W + 1)'(tr_reg) *
                         (R_W + PI_HI_W + 1)'(PI_Q32[PI_W-1:PI_LO_W]);

            tag3_reg  <= tag_next;
            ok3_reg   <= ok2_reg;
            pp_ll_reg <= (X_LO_W + Y_LO_W)'(x_reg[X_LO_W-1:0]) *
                         (X_LO_W + Y_LO_W)'(y_reg[Y_LO_W-1:0]);
            pp_lh_reg <= (X_LO_W + Y_HI_W)'(x_reg[X_LO_W-1:0]) *
                         (X_LO_W + Y_HI_W)'(y_reg[Y_W-1:Y_LO_W]);
            pp_hl_reg <= (X_HI_W + Y_LO_W)'(x_reg[X_W-1:X_LO_W]) *
                         (X_HI_W + Y_LO_W)'(y_reg[Y_LO_W-1:0]);
            pp_hh_reg <= (X_HI_W + Y_HI_W)'(x_reg[X_W-1:X_LO_W]) *
                         (X_HI_W + Y_HI_W)'(y_reg[Y_W-1:Y_LO_W]);

            tag4_reg  <= tag3_reg;
            ok4_reg   <= ok3_reg;
            cat_reg   <= {pp_hh_reg, pp_ll_reg};
            mid_reg   <= (PROD_W'(pp_lh_reg) << Y_LO_W) + (PROD_W'(pp_hl_reg) << X_LO_W);

            tag5_reg  <= tag4_reg;
            p_reg     <= ok4_reg ? AREA_RAD_W'(prod >> HERON_SH) : '0;
        end
    end

    for (genvar k = 0; k < AREA_ROOT_W; k++) begin : g_tag
        always_ff @(posedge aclk) begin
            if (en) begin
                tag_dly_reg[k] <= (k == 0) ? tag5_reg : tag_dly_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    hta_isqrt #(
        .IN_W (AREA_RAD_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[4]),
        .rad_in    (p_reg),
        .out_valid (root_valid),
        .root_out  (root)
    );

    assign tag_out = tag_dly_reg[AREA_ROOT_W-1];
    assign t_area  = (root > AREA_ROOT_W'(AREA_MAX)) ? AREA_MAX : AREA_W'(root);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (tag_out.op == OP_CIRCLE) begin
                area_reg      <= tag_out.rneg ? '0 : tag_out.c_area;
                perimeter_reg <= tag_out.rneg ? '0 : tag_out.c_perim;
                error_reg     <= tag_out.rneg;
            end else begin
                area_reg      <= t_area;
                perimeter_reg <= tag_out.t_perim;
                error_reg     <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign area      = area_reg;
    assign perimeter = perimeter_reg;
    assign error     = error_reg;

endmodule

// ===== design/triangle_circle_area_perimeter.sv =====
// top level: input stage, three side lanes, merge stage and output skid buffer
// throughput: one figure per cycle while the pipeline is not stalled, set by the fully
// pipelined lanes, multipliers and root stages
// the whole pipeline stalls only while the output skid register holds a waiting result
// reset: synchronous active-low aresetn clears all valid bits and the output and skid flags
// no clearing pass; the block accepts beats in the first cycle after reset
module triangle_circle_area_perimeter
    import hta_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // x_a, y_a, x_b, y_b, x_c, y_c
    input  logic                 s_tuser,  // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // area, perimeter, zero pad
    output logic                 m_tuser   // error
);

    typedef struct packed {
        opcode_t                       op;
        logic signed [COORD_WIDTH-1:0] radius;
    } circ_t;

    logic                          en;
    logic                          in_valid_reg;
    opcode_t                       op_reg;
    logic signed [COORD_WIDTH-1:0] xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg;
    circ_t                         dly_reg [LANE_LAT];

    logic [2:0]        lane_valid;
    logic [SIDE_W-1:0] side_a, side_b, side_c;

    logic               mrg_valid;
    logic [AREA_W-1:0]  mrg_area;
    logic [PERIM_W-1:0] mrg_perim;
    logic               mrg_error;
    logic [M_TDATA_W-1:0] mrg_data;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;
    logic                 skid_full_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;
    logic                 skid_user_reg;

    assign en       = !skid_full_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg <= opcode_t'(s_tuser);
            xa_reg <= s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
            ya_reg <= s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
            xb_reg <= s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
            yb_reg <= s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
            xc_reg <= s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
            yc_reg <= s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    // opcode and radius ride alongside the lanes
    for (genvar k = 0; k < LANE_LAT; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                if (k == 0) begin
                    dly_reg[k] <= '{op: op_reg, radius: xb_reg};
                end else begin
                    dly_reg[k] <= dly_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    hta_lane u_lane_a (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_valid (in_valid_reg),
        .x0 (xa_reg), .y0 (ya_reg), .x1 (xb_reg), .y1 (yb_reg),
        .out_valid (lane_valid[0]), .side_len (side_a)
    );

    hta_lane u_lane_b (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_valid (in_valid_reg),
        .x0 (xb_reg), .y0 (yb_reg), .x1 (xc_reg), .y1 (yc_reg),
        .out_valid (lane_valid[1]), .side_len (side_b)
    );

    hta_lane u_lane_c (
        .aclk (aclk), .aresetn (aresetn), .en (en), .in_valid (in_valid_reg),
        .x0 (xc_reg), .y0 (yc_reg), .x1 (xa_reg), .y1 (ya_reg),
        .out_valid (lane_valid[2]), .side_len (side_c)
    );

    hta_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (lane_valid[0]),
        .side_a    (side_a),
        .side_b    (side_b),
        .side_c    (side_c),
        .opcode    (dly_reg[LANE_LAT-1].op),
        .radius    (dly_reg[LANE_LAT-1].radius),
        .out_valid (mrg_valid),
        .area      (mrg_area),
        .perimeter (mrg_perim),
        .error     (mrg_error)
    );

    assign mrg_data = {{M_PAD_W{1'b0}}, mrg_perim, mrg_area};

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_tready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (m_tready || !m_valid_reg) begin
            m_valid_reg <= mrg_valid;
        end else if (mrg_valid) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_full_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end
        end else if (m_tready || !m_valid_reg) begin
            m_data_reg <= mrg_data;
            m_user_reg <= mrg_error;
        end else begin
            skid_data_reg <= mrg_data;
            skid_user_reg <= mrg_error;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_valid[0] == lane_valid[1]) && (lane_valid[0] == lane_valid[2]))
        else $error("side lanes out of step");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[AREA_W+PERIM_W-1:0] == '0))
        else $error("error beat with nonzero results");

    a_skid_has_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid full with empty output register");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_full_reg && m_tready) |=> (!skid_full_reg && m_valid_reg))
        else $error("skid beat not moved to output");

endmodule
